// ===== sv/ptfl_pkg.sv =====
// Shared types and constants for the page table free-list allocator.
// No dependencies; imported by every module of the block except ptfl_ram.
package ptfl_pkg;

    // Parameter defaults
    localparam int TABLE_PAGES_DEF    = 4096;
    localparam int FILE_PAGE_BITS_DEF = 32;

    // Fixed field widths of the stream words
    localparam int PAGE_ID_W   = 12;
    localparam int FILE_PAGE_W = 32;
    localparam int STATUS_W    = 2;
    localparam int LIVE_W      = 13;
    localparam int MODE_W      = 2;

    // Input tdata: page id, file page (low to high), padded to bytes
    localparam int IN_TDATA_W  = 48;
    // Output tdata: granted page, file page found, mapped, status, live count
    localparam int OUT_TDATA_W = 64;

    // Output field positions
    localparam int OUT_FP_LSB     = PAGE_ID_W;
    localparam int OUT_MAPPED_BIT = OUT_FP_LSB + FILE_PAGE_W;
    localparam int OUT_STATUS_LSB = OUT_MAPPED_BIT + 1;
    localparam int OUT_LIVE_LSB   = OUT_STATUS_LSB + STATUS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_MAP    = 2'd2,
        MODE_LOOKUP = 2'd3
    } t_mode;

    // Entry tag, low two bits of each table entry
    typedef enum logic [1:0] {
        TAG_UNMAPPED = 2'd0,
        TAG_MAPPED   = 2'd1,
        TAG_LINK     = 2'd2,
        TAG_TAIL     = 2'd3
    } t_tag;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // latch input word, launch table read
        logic fire;     // execute, write table, load output word
    } t_cmd;

endpackage

// ===== sv/page_table_free_list_allocator.sv =====
// Top level of the page table allocator with an embedded free list.
// Depends on ptfl_pkg, ptfl_ctrl, ptfl_dp (which holds ptfl_ram).
//
// Usage:
//   Slave stream carries one operation per word: tuser selects allocate, free,
//   map or lookup; tdata carries the page id and the file page to record.
//   Master stream returns one result word per operation: granted or echoed
//   page, file page found by lookup, mapped flag, status and live page count.
// Sequence:
//   An operation has an accept and an execute step: the accept edge launches
//   the table read (list head for allocate, addressed page otherwise), the
//   execute edge writes the table and loads the result word, raising tvalid.
//   The slave side takes no new word until the execute step has fired.
// Stalls:
//   A result waiting on the master side does not block the next accept; the
//   following operation waits in its execute step until the output register
//   drains, with its table read data held.
// Reset:
//   Synchronous active-low reset empties the table (size 0, free list empty);
//   the RAM is not cleared, entries are written before they are read.
module page_table_free_list_allocator #(
    parameter int TABLE_PAGES    = ptfl_pkg::TABLE_PAGES_DEF,
    parameter int FILE_PAGE_BITS = ptfl_pkg::FILE_PAGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [11:0] page_id, [43:12] fpage, [47:44] zero
    input  logic [ptfl_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [1:0] mode
    input  logic [ptfl_pkg::MODE_W-1:0]        i_s_axis_tuser,
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [11:0] page_out, [43:12] fpage_out, [44] mapped, [46:45] status,
    // [59:47] live_count, [63:60] zero
    output logic [ptfl_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import ptfl_pkg::*;

    t_cmd cmd;

    ptfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    ptfl_dp #(
        .TABLE_PAGES    (TABLE_PAGES),
        .FILE_PAGE_BITS (FILE_PAGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (t_mode'(i_s_axis_tuser)),
        .i_page_id   (i_s_axis_tdata[PAGE_ID_W-1:0]),
        .i_fpage     (i_s_axis_tdata[PAGE_ID_W +: FILE_PAGE_W]),
        .o_tdata     (o_m_axis_tdata)
    );

endmodule

// ===== sv/ptfl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ptfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ptfl_ctrl.sv =====
// Sequencer for the allocator: handshakes and the two-step read/execute flow.
// Depends on ptfl_pkg.
module ptfl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ptfl_pkg::t_cmd  o_cmd
);
    import ptfl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   fire;

    // execute once the output register is free or draining this cycle
    assign fire = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = '{accept: (r_state == S_IDLE) && i_in_valid, fire: fire};

endmodule

// ===== sv/ptfl_dp.sv =====
// Datapath: page table RAM, free-list head, size and free counters, result register.
// Depends on ptfl_pkg and ptfl_ram.
module ptfl_dp #(
    parameter int TABLE_PAGES    = ptfl_pkg::TABLE_PAGES_DEF,
    parameter int FILE_PAGE_BITS = ptfl_pkg::FILE_PAGE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptfl_pkg::t_cmd                     i_cmd,
    input  ptfl_pkg::t_mode                    i_mode,
    input  logic [ptfl_pkg::PAGE_ID_W-1:0]     i_page_id,
    input  logic [ptfl_pkg::FILE_PAGE_W-1:0]   i_fpage,
    output logic [ptfl_pkg::OUT_TDATA_W-1:0]   o_tdata
);
    import ptfl_pkg::*;

    localparam int PAGE_W  = $clog2(TABLE_PAGES);
    localparam int SIZE_W  = $clog2(TABLE_PAGES + 1);
    localparam int PL_W    = (FILE_PAGE_BITS > PAGE_W) ? FILE_PAGE_BITS : PAGE_W;
    localparam int ENTRY_W = PL_W + 2;
    localparam int CW0     = (PL_W > SIZE_W) ? PL_W : SIZE_W;
    localparam int CW      = (CW0 > PAGE_ID_W) ? CW0 : PAGE_ID_W;
    localparam logic [PL_W-1:0]   FP_MASK  = {PL_W{1'b1}} >> (PL_W - FILE_PAGE_BITS);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(TABLE_PAGES);

    // latched operation
    t_mode                  r_mode;
    logic [PAGE_ID_W-1:0]   r_pid;
    logic [FILE_PAGE_W-1:0] r_fp;

    // table state
    logic [SIZE_W-1:0] r_size, n_size;
    logic [PAGE_W-1:0] r_head, n_head;
    logic              r_empty, n_empty;
    logic [SIZE_W-1:0] r_free, n_free;

    // result register
    logic [OUT_TDATA_W-1:0] r_out;

    // RAM interface
    logic               we;
    logic [PAGE_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [PAGE_W-1:0]  raddr;
    logic [ENTRY_W-1:0] rdata;

    // decoded read entry
    t_tag              tag;
    logic [PL_W-1:0]   payload;
    logic              is_free;
    logic              in_range;
    logic [PL_W-1:0]   fp_masked;

    // result fields
    logic [PAGE_ID_W-1:0]   page_out;
    logic [FILE_PAGE_W-1:0] fp_out;
    logic                   hit;
    t_status                status;
    logic [LIVE_W-1:0]      live;

    // allocate reads the list head; the others read the addressed page
    assign raddr = (i_mode == MODE_ALLOC) ? r_head : PAGE_W'(i_page_id);

    ptfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_PAGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign tag       = t_tag'(rdata[1:0]);
    assign payload   = rdata[ENTRY_W-1:2];
    assign is_free   = (tag == TAG_LINK) || (tag == TAG_TAIL);
    assign in_range  = CW'(r_pid) < CW'(r_size);
    assign fp_masked = PL_W'(r_fp) & FP_MASK;

    always_comb begin
        n_size   = r_size;
        n_head   = r_head;
        n_empty  = r_empty;
        n_free   = r_free;
        we       = 1'b0;
        waddr    = PAGE_W'(r_pid);
        wdata    = {{PL_W{1'b0}}, TAG_UNMAPPED};
        page_out = r_pid;
        fp_out   = '0;
        hit      = 1'b0;
        status   = ST_OK;

        unique case (r_mode)
            MODE_ALLOC: begin
                if (!r_empty && (CW'(r_head) < CW'(r_size))) begin
                    // pop head; anything but a link to an in-range page ends the list
                    if ((tag == TAG_LINK) && (CW'(payload) < CW'(r_size))) begin
                        n_head = PAGE_W'(payload);
                    end else begin
                        n_empty = 1'b1;
                        n_head  = '0;
                    end
                    we    = 1'b1;
                    waddr = r_head;
                    if (r_free != '0) begin
                        n_free = r_free - 1'b1;
                    end
                    page_out = PAGE_ID_W'(r_head);
                end else if (r_size < SIZE_MAX) begin
                    // grow the table by one entry
                    we       = 1'b1;
                    waddr    = PAGE_W'(r_size);
                    page_out = PAGE_ID_W'(r_size);
                    n_size   = r_size + 1'b1;
                end else begin
                    page_out = '0;
                    status   = ST_FULL;
                end
            end
            MODE_FREE: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (!is_free) begin
                    we = 1'b1;
                    if (r_empty) begin
                        wdata = {{PL_W{1'b0}}, TAG_TAIL};
                    end else begin
                        wdata = {PL_W'(r_head), TAG_LINK};
                    end
                    n_head  = PAGE_W'(r_pid);
                    n_empty = 1'b0;
                    n_free  = r_free + 1'b1;
                end
            end
            MODE_MAP: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (!is_free) begin
                    we    = 1'b1;
                    wdata = {fp_masked, TAG_MAPPED};
                end
            end
            MODE_LOOKUP: begin
                if (!in_range) begin
                    status = ST_RANGE;
                end else if (tag == TAG_MAPPED) begin
                    fp_out = FILE_PAGE_W'(payload & FP_MASK);
                    hit    = 1'b1;
                end
            end
            default: status = ST_OK;
        endcase

        if (!i_cmd.fire) begin
            we = 1'b0;
        end

        live = (n_size >= n_free) ? LIVE_W'(n_size - n_free) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_pid  <= i_page_id;
            r_fp   <= i_fpage;
        end
        if (i_cmd.fire) begin
            r_out <= OUT_TDATA_W'({live, status, hit, fp_out, page_out});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_head  <= '0;
            r_empty <= 1'b1;
            r_free  <= '0;
        end else if (i_cmd.fire) begin
            r_size  <= n_size;
            r_head  <= n_head;
            r_empty <= n_empty;
            r_free  <= n_free;
        end
    end

    assign o_tdata = r_out;

endmodule

// ===== sv/ptfl_chk.sv =====
// Port-level checker for the allocator, attached by bind.
// Depends on ptfl_pkg and page_table_free_list_allocator.
module ptfl_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [ptfl_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import ptfl_pkg::*;

    logic [STATUS_W-1:0] st;
    assign st = o_m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];

    // a held result word stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // one operation at a time: no accept on the edge after an accept
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("accepted back to back");

    // failed operations never report a mapping
    a_fail_nomap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (st != ST_OK) |->
            !o_m_axis_tdata[OUT_MAPPED_BIT] &&
            (o_m_axis_tdata[OUT_FP_LSB +: FILE_PAGE_W] == '0))
        else $error("mapping reported on failed operation");

    // table full grants page zero; status code is always defined
    a_full_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (st == ST_OK || st == ST_RANGE ||
             (st == ST_FULL && o_m_axis_tdata[PAGE_ID_W-1:0] == '0)))
        else $error("bad status or full without page zero");

endmodule

bind page_table_free_list_allocator ptfl_chk u_ptfl_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
